/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define AST_IMPL(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error(msg);
// Next-cycle implication.
`define AST_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);
`endif

/* rtl/atan2_pkg.sv */
// Shared types and constants for the atan2 pipeline.
package atan2_pkg;
	// pi scaled by 2^62
	localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;
	localparam int NUM_K = 25;
	localparam int DEN_K = 7;

	// Per-item control that rides along with the divider.
	typedef struct packed {
		logic xzero;
		logic yzero;
		logic xneg;
		logic yneg;
		logic steep;
		logic pneg;
	} ctl_t;
endpackage

/* rtl/atan2_div_stage.sv */
// One restoring-division step of the fraction divider, registered.
module atan2_div_stage #(
	parameter int NW = 72,
	parameter int QW = 13
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_in,
	input  logic [NW-1:0] num_in,
	input  logic [NW-1:0] den_in,
	input  logic [QW-1:0] q_in,
	input  atan2_pkg::ctl_t ctl_in,
	output logic          vld_out,
	output logic [NW-1:0] num_out,
	output logic [NW-1:0] den_out,
	output logic [QW-1:0] q_out,
	output atan2_pkg::ctl_t ctl_out
);
	logic [NW:0] sh;
	logic        ge;

	always_comb begin
		sh = {num_in, 1'b0};
		ge = (sh >= {1'b0, den_in});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_out <= ge ? NW'(sh - {1'b0, den_in}) : sh[NW-1:0];
			den_out <= den_in;
			q_out   <= {q_in[QW-2:0], ge};
			ctl_out <= ctl_in;
		end
	end
endmodule

/* rtl/atan2_rational_approx.sv */
// Top level: pipelined four-quadrant atan2 by z/(1+0.28z^2).
//
// Channel  Dir  Handshake           Payload
// in       in   in_valid/in_ready   x_coord, y_coord
// out      out  out_valid/out_ready angle
//
// One item per cycle sustained unless out_ready stalls the output.
// Stages: magnitudes, squares, scaled sums, then one restoring
// division step per stage, then sign and quadrant correction.
// The whole pipe advances when the output stage is empty or taken,
// so a stall freezes every stage and nothing is lost or repeated.
// Reset clears valid bits only.
`include "assert_macros.svh"
module atan2_rational_approx #(
	parameter int COORD_WIDTH = 16,
	parameter int FRAC_BITS   = 13
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_WIDTH-1:0] x_coord,
	input  logic signed [COORD_WIDTH-1:0] y_coord,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [FRAC_BITS+2:0]  angle
);
	localparam int CW = COORD_WIDTH;
	localparam int MW = CW + 1;          // magnitude incl. most negative
	localparam int SW = 2 * MW;          // square / product
	localparam int NW = SW + 6;          // scaled sums, room for shift
	localparam int OW = FRAC_BITS + 3;
	localparam logic [63:0] PI_R = (atan2_pkg::PI_Q62 +
		(64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS);
	localparam logic [63:0] HP_R = (atan2_pkg::PI_Q62 +
		(64'd1 << (62 - FRAC_BITS))) >> (63 - FRAC_BITS);
	localparam logic signed [OW-1:0] PI_Q = OW'(PI_R);
	localparam logic signed [OW-1:0] HALF_Q = OW'(HP_R);

	logic en;

	// stage 1: magnitudes and signs
	logic vld_s1;
	logic [MW-1:0] ax_s1, ay_s1;
	logic xn_s1, yn_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			xn_s1 <= x_coord[CW-1];
			yn_s1 <= y_coord[CW-1];
			ax_s1 <= x_coord[CW-1] ? MW'(-{x_coord[CW-1], x_coord}) : MW'({1'b0, x_coord});
			ay_s1 <= y_coord[CW-1] ? MW'(-{y_coord[CW-1], y_coord}) : MW'({1'b0, y_coord});
		end
	end

	// stage 2: squares and cross product (one multiply each)
	logic vld_s2;
	logic [SW-1:0] xx_s2, yy_s2, xy_s2;
	atan2_pkg::ctl_t ctl_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (en) vld_s2 <= vld_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			xx_s2 <= ax_s1 * ax_s1;
			yy_s2 <= ay_s1 * ay_s1;
			xy_s2 <= ax_s1 * ay_s1;
			ctl_s2.xzero <= (ax_s1 == '0);
			ctl_s2.yzero <= (ay_s1 == '0);
			ctl_s2.xneg  <= xn_s1;
			ctl_s2.yneg  <= yn_s1;
			ctl_s2.steep <= !(ay_s1 < ax_s1);
			ctl_s2.pneg  <= (xn_s1 != yn_s1) && (ay_s1 != '0);
		end
	end

	// stage 3: numerator 25xy, denominator 25a^2 + 7b^2 (constant multiplies)
	logic vld_s3;
	logic [NW-1:0] num_s3, den_s3;
	atan2_pkg::ctl_t ctl_s3;
	logic [SW-1:0] big, sml;
	always_comb begin
		big = ctl_s2.steep ? yy_s2 : xx_s2;
		sml = ctl_s2.steep ? xx_s2 : yy_s2;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (en) vld_s3 <= vld_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			num_s3 <= NW'(xy_s2) * NW'(atan2_pkg::NUM_K);
			den_s3 <= NW'(big) * NW'(atan2_pkg::NUM_K) + NW'(sml) * NW'(atan2_pkg::DEN_K);
			ctl_s3 <= ctl_s2;
		end
	end

	// division chain: one quotient bit per stage
	logic [FRAC_BITS:0] dv_vld;
	logic [NW-1:0] dv_num [FRAC_BITS+1];
	logic [NW-1:0] dv_den [FRAC_BITS+1];
	logic [FRAC_BITS-1:0] dv_q [FRAC_BITS+1];
	atan2_pkg::ctl_t dv_ctl [FRAC_BITS+1];
	assign dv_vld[0] = vld_s3;
	assign dv_num[0] = num_s3;
	assign dv_den[0] = den_s3;
	assign dv_q[0]   = '0;
	assign dv_ctl[0] = ctl_s3;
	for (genvar i = 0; i < FRAC_BITS; i++) begin : g_div
		atan2_div_stage #(.NW(NW), .QW(FRAC_BITS)) u_stage (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_in(dv_vld[i]), .num_in(dv_num[i]), .den_in(dv_den[i]),
			.q_in(dv_q[i]), .ctl_in(dv_ctl[i]),
			.vld_out(dv_vld[i+1]), .num_out(dv_num[i+1]), .den_out(dv_den[i+1]),
			.q_out(dv_q[i+1]), .ctl_out(dv_ctl[i+1])
		);
	end

	// final stage: sign and quadrant correction into the output register
	atan2_pkg::ctl_t c;
	logic signed [OW-1:0] sq, res;
	always_comb begin
		c  = dv_ctl[FRAC_BITS];
		sq = c.pneg ? -OW'(dv_q[FRAC_BITS]) : OW'(dv_q[FRAC_BITS]);
		if (c.xzero) begin
			res = c.yzero ? '0 : (c.yneg ? -HALF_Q : HALF_Q);
		end else if (!c.steep) begin
			res = sq;
			if (c.xneg) res = c.yneg ? sq - PI_Q : sq + PI_Q;
		end else begin
			res = HALF_Q - sq;
			if (c.yneg) res = res - PI_Q;
		end
	end

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= dv_vld[FRAC_BITS];
	end
	always_ff @(posedge clk) begin
		if (en) angle <= res;
	end

	`AST_NEXT(a_stall_holds, clk, arst_n, out_valid && !out_ready, $stable(angle) && out_valid, "output changed during stall")
	`AST_IMPL(a_ready_follows, clk, arst_n, 1'b1, in_ready == (!out_valid || out_ready), "in_ready mismatch")
	`AST_NEXT(a_frozen_pipe, clk, arst_n, !en, $stable(vld_s3) && $stable(dv_vld), "pipe moved while stalled")
endmodule
